@@ rtl/ecos_pkg.sv @@
// ----------------------------------------------------------------------------
// ecos_pkg: shared types and constants
// Payload structs, per-instrument state layout, configuration registers and
// the codes used by the EMA crossover order block.
// ----------------------------------------------------------------------------
package ecos_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 56;
    localparam int INST_EXT_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_FAST_WEIGHT      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOW_WEIGHT      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VOLATILITY_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CROSS_BAND       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_POSITION_LIMIT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LOT_SIZE         = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TICK_STEP        = 3'd6;

    localparam logic [1:0] KIND_BUY   = 2'd0;
    localparam logic [1:0] KIND_SELL  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    localparam logic [16:0] WEIGHT_ONE = 17'd65536;

    typedef struct packed {
        logic [7:0]  instrument;
        logic [3:0]  levels;
        logic [27:0] bid_price;
        logic [27:0] ask_price;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  order_instrument;
        logic [63:0] order_number;
        logic [1:0]  order_kind;
        logic        order_side;
        logic [28:0] order_price;
        logic [10:0] order_qty;
    } order_t;

    typedef struct packed {
        logic [16:0] fast_weight;
        logic [16:0] slow_weight;
        logic [55:0] volatility_limit;
        logic [31:0] cross_band;
        logic [9:0]  position_limit;
        logic [9:0]  lot_size;
        logic [9:0]  tick_step;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        fast_weight:      17'd6553,
        slow_weight:      17'd1310,
        volatility_limit: 56'd429496729600,
        cross_band:       32'd131072,
        position_limit:   10'd1000,
        lot_size:         10'd100,
        tick_step:        10'd1
    };

    typedef struct packed {
        logic [44:0] fast_avg;
        logic [44:0] slow_avg;
        logic [55:0] volatility;
        logic [27:0] last_mid;
        logic [11:0] holding;
        logic        seeded;
    } inst_state_t;

    typedef struct packed {
        logic state_we;
        logic order_valid;
    } upd_ctl_t;

endpackage

@@ rtl/ema_crossover_order_signal.sv @@
// Takes one top-of-book update per cycle, unless a stalled result channel holds the state
// stage, and returns at most one order for it. An accepted update reaches the state stage in
// the next cycle; its order, if any, is registered onto the result channel when that stage
// fires, which a stalled result channel can delay. Unstalled, the rate of one update per cycle
// rests on the read-modify-write of the per-instrument state memory with forwarding from its
// most recent write. After reset the block clears the state memory, one entry per cycle, and
// accepts no update until that pass is done; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// ema_crossover_order_signal: EMA crossover order generator
// Keeps fast and slow averages, volatility and position per instrument and
// issues buy, sell and close orders with a running order number.
// ----------------------------------------------------------------------------
module ema_crossover_order_signal #(
    parameter int INSTRUMENTS = 256,
    parameter int PRICE_WIDTH = 28
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ecos_pkg::in_item_t                 s_payload,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ecos_pkg::order_t                   m_payload,
    input  logic                               cfg_wr_en,
    input  logic [ecos_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  logic [ecos_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    localparam int AW = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;
    localparam int SW = $bits(ecos_pkg::inst_state_t);
    localparam logic [AW-1:0] LAST_ADDR = AW'(INSTRUMENTS - 1);

    ecos_pkg::cfg_t        cfg;
    ecos_pkg::in_item_t    s1_item_reg;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  clearing_reg;
    logic                  clearing_next;
    logic [AW-1:0]         clr_addr_reg;
    logic [AW-1:0]         clr_addr_next;
    logic                  fwd_valid_reg;
    logic [AW-1:0]         fwd_addr_reg;
    ecos_pkg::inst_state_t fwd_data_reg;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    ecos_pkg::order_t      m_payload_reg;
    logic [63:0]           order_number_reg;
    logic [63:0]           order_number_next;

    logic [ecos_pkg::INST_EXT_W-1:0] in_inst_ext;
    logic [ecos_pkg::INST_EXT_W-1:0] s1_inst_ext;
    logic [AW-1:0]         in_addr;
    logic [AW-1:0]         s1_addr;
    logic                  in_fire;
    logic                  s1_fire;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [SW-1:0]         ram_wdata;
    logic [SW-1:0]         ram_rdata;
    ecos_pkg::inst_state_t state_cur;
    ecos_pkg::inst_state_t state_new;
    ecos_pkg::upd_ctl_t    ctl;
    ecos_pkg::order_t      order;
    logic                  load_order;

    ecos_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    assign in_inst_ext = ecos_pkg::INST_EXT_W'(s_payload.instrument);
    assign s1_inst_ext = ecos_pkg::INST_EXT_W'(s1_item_reg.instrument);
    assign in_addr     = in_inst_ext[AW-1:0];
    assign s1_addr     = s1_inst_ext[AW-1:0];

    assign s1_fire = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !clearing_reg && (!s1_valid_reg || s1_fire);
    assign in_fire = s_valid && s_ready;

    ecos_ram #(
        .WIDTH (SW),
        .DEPTH (INSTRUMENTS),
        .AW    (AW)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (in_fire),
        .rd_addr (in_addr),
        .rd_data (ram_rdata)
    );

    assign state_cur = (fwd_valid_reg && (fwd_addr_reg == s1_addr))
                     ? fwd_data_reg : ecos_pkg::inst_state_t'(ram_rdata);

    ecos_update #(
        .INSTRUMENTS (INSTRUMENTS),
        .PRICE_WIDTH (PRICE_WIDTH)
    ) u_update (
        .item         (s1_item_reg),
        .state_cur    (state_cur),
        .cfg          (cfg),
        .order_number (order_number_reg),
        .state_new    (state_new),
        .ctl          (ctl),
        .order        (order)
    );

    assign ram_we     = clearing_reg || (s1_fire && ctl.state_we);
    assign ram_waddr  = clearing_reg ? clr_addr_reg : s1_addr;
    assign ram_wdata  = clearing_reg ? '0 : SW'(state_new);
    assign load_order = s1_fire && ctl.order_valid;

    always_comb begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            if (clr_addr_reg == LAST_ADDR) begin
                clearing_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + AW'(1);
            end
        end

        if (in_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        if (load_order) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end

        order_number_next = load_order ? order_number_reg + 64'd1 : order_number_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg     <= 1'b1;
            clr_addr_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
            order_number_reg <= 64'd1;
        end else begin
            clearing_reg     <= clearing_next;
            clr_addr_reg     <= clr_addr_next;
            s1_valid_reg     <= s1_valid_next;
            fwd_valid_reg    <= fwd_valid_reg || ram_we;
            m_valid_reg      <= m_valid_next;
            order_number_reg <= order_number_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_item_reg <= s_payload;
        end
        if (ram_we) begin
            fwd_addr_reg <= ram_waddr;
            fwd_data_reg <= ecos_pkg::inst_state_t'(ram_wdata);
        end
        if (load_order) begin
            m_payload_reg <= order;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef SYNTH
    a_clear_blocks_items: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> (!s_ready && !s1_valid_reg))
        else $error("Update accepted during the state clearing pass.");

    a_order_number_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        load_order |=> (order_number_reg == $past(order_number_reg) + 64'd1))
        else $error("Order number did not advance with an issued order.");

    a_order_needs_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && ctl.order_valid) |-> state_cur.seeded)
        else $error("Order issued for an instrument that was never seeded.");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("Stalled update left the state stage.");
`endif

endmodule

@@ rtl/ecos_ram.sv @@
// ----------------------------------------------------------------------------
// ecos_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ecos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ecos_cfg.sv @@
// ----------------------------------------------------------------------------
// ecos_cfg: configuration register bank
// Holds the smoothing weights, limits, cross band, lot size and tick step.
// ----------------------------------------------------------------------------
module ecos_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [ecos_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  logic [ecos_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    output ecos_pkg::cfg_t                     cfg
);

    ecos_pkg::cfg_t cfg_reg;
    ecos_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                ecos_pkg::REG_FAST_WEIGHT: begin
                    cfg_next.fast_weight = cfg_wr_data[16:0];
                end
                ecos_pkg::REG_SLOW_WEIGHT: begin
                    cfg_next.slow_weight = cfg_wr_data[16:0];
                end
                ecos_pkg::REG_VOLATILITY_LIMIT: begin
                    cfg_next.volatility_limit = cfg_wr_data[55:0];
                end
                ecos_pkg::REG_CROSS_BAND: begin
                    cfg_next.cross_band = cfg_wr_data[31:0];
                end
                ecos_pkg::REG_POSITION_LIMIT: begin
                    cfg_next.position_limit = cfg_wr_data[9:0];
                end
                ecos_pkg::REG_LOT_SIZE: begin
                    cfg_next.lot_size = cfg_wr_data[9:0];
                end
                ecos_pkg::REG_TICK_STEP: begin
                    cfg_next.tick_step = cfg_wr_data[9:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= ecos_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/ecos_update.sv @@
// ----------------------------------------------------------------------------
// ecos_update: per-update state refresh and order decision
// Refreshes the averages, volatility and position of one instrument and
// decides whether the update issues a buy, sell or close order.
// ----------------------------------------------------------------------------
module ecos_update #(
    parameter int INSTRUMENTS = 256,
    parameter int PRICE_WIDTH = 28
) (
    input  ecos_pkg::in_item_t    item,
    input  ecos_pkg::inst_state_t state_cur,
    input  ecos_pkg::cfg_t        cfg,
    input  logic [63:0]           order_number,
    output ecos_pkg::inst_state_t state_new,
    output ecos_pkg::upd_ctl_t    ctl,
    output ecos_pkg::order_t      order
);

    localparam logic [27:0] PRICE_MASK = 28'((29'(1) << PRICE_WIDTH) - 29'(1));

    // The weighted difference is formed from two narrow partial products.
    function automatic logic [44:0] ema_step(input logic [44:0] avg,
                                             input logic [43:0] target,
                                             input logic [16:0] w);
        logic [16:0]        wc;
        logic signed [45:0] d;
        logic [22:0]        d_lo;
        logic signed [22:0] d_hi;
        logic [39:0]        p_lo;
        logic signed [40:0] p_hi;
        logic signed [63:0] prod;
        logic signed [63:0] step;
        logic [45:0]        sum;
        wc   = (w > ecos_pkg::WEIGHT_ONE) ? ecos_pkg::WEIGHT_ONE : w;
        d    = $signed({2'b00, target}) - $signed({1'b0, avg});
        d_lo = d[22:0];
        d_hi = d[45:23];
        p_lo = wc * d_lo;
        p_hi = $signed({1'b0, wc}) * d_hi;
        prod = (64'(p_hi) <<< 23) + $signed({24'd0, p_lo});
        step = prod >>> 16;
        sum  = {1'b0, avg} + step[45:0];
        return sum[44:0];
    endfunction

    logic [ecos_pkg::INST_EXT_W-1:0] inst_ext;
    logic               in_range;
    logic               book_ok;
    logic [27:0]        bid;
    logic [27:0]        ask;
    logic [28:0]        price_sum;
    logic [27:0]        mid;
    logic [43:0]        scaled;
    logic [44:0]        fast_new;
    logic [44:0]        slow_new;
    logic signed [28:0] delta;
    logic [27:0]        delta_mag;
    logic [55:0]        delta_sq;
    logic [63:0]        vol_acc;
    logic [55:0]        vol_new;
    logic [27:0]        spread;
    logic               quiet;
    logic signed [45:0] diff;
    logic signed [45:0] band;
    logic signed [11:0] pos;
    logic signed [11:0] lim;
    logic signed [11:0] lot;
    logic               do_buy;
    logic               do_sell;
    logic               do_close;
    logic               issue;
    logic [11:0]        hold_new;

    assign inst_ext = ecos_pkg::INST_EXT_W'(item.instrument);
    assign in_range = inst_ext < ecos_pkg::INST_EXT_W'(INSTRUMENTS);
    assign bid      = item.bid_price & PRICE_MASK;
    assign ask      = item.ask_price & PRICE_MASK;
    assign book_ok  = (item.levels != 4'd0) && (bid != 28'd0) && (ask != 28'd0) && (ask > bid);

    assign price_sum = 29'(bid) + 29'(ask);
    assign mid       = price_sum[28:1];
    assign scaled    = {mid, 16'd0};

    assign fast_new = ema_step(state_cur.fast_avg, scaled, cfg.fast_weight);
    assign slow_new = ema_step(state_cur.slow_avg, scaled, cfg.slow_weight);

    assign delta     = $signed({1'b0, mid}) - $signed({1'b0, state_cur.last_mid});
    assign delta_mag = delta[28] ? 28'(-delta) : delta[27:0];
    assign delta_sq  = delta_mag * delta_mag;
    assign vol_acc   = {1'b0, state_cur.volatility, 7'd0} - 64'(state_cur.volatility)
                     + 64'(delta_sq);
    assign vol_new   = vol_acc[62:7];

    assign spread = ask - bid;
    assign quiet  = (vol_new <= cfg.volatility_limit) && (spread >= 28'(cfg.tick_step));

    assign diff = $signed({1'b0, fast_new}) - $signed({1'b0, slow_new});
    assign band = $signed({14'd0, cfg.cross_band});
    assign pos  = $signed(state_cur.holding);
    assign lim  = $signed({2'b00, cfg.position_limit});
    assign lot  = $signed({2'b00, cfg.lot_size});

    assign do_buy   = (diff > band) && (pos < lim);
    assign do_sell  = !do_buy && (diff < -band) && (pos > -lim);
    assign do_close = !do_buy && !do_sell
                    && (((pos > 12'sd0) && (diff < 46'sd0)) || ((pos < 12'sd0) && (diff > 46'sd0)));
    assign issue    = quiet && (do_buy || do_sell || do_close);

    always_comb begin
        if (do_buy) begin
            hold_new = pos + lot;
        end else if (do_sell) begin
            hold_new = pos - lot;
        end else begin
            hold_new = 12'd0;
        end
    end

    always_comb begin
        ctl.state_we    = in_range && book_ok;
        ctl.order_valid = in_range && book_ok && state_cur.seeded && issue;
        if (!state_cur.seeded) begin
            state_new.fast_avg   = {1'b0, scaled};
            state_new.slow_avg   = {1'b0, scaled};
            state_new.volatility = 56'd0;
            state_new.last_mid   = mid;
            state_new.holding    = 12'd0;
            state_new.seeded     = 1'b1;
        end else begin
            state_new.fast_avg   = fast_new;
            state_new.slow_avg   = slow_new;
            state_new.volatility = vol_new;
            state_new.last_mid   = mid;
            state_new.holding    = issue ? hold_new : state_cur.holding;
            state_new.seeded     = 1'b1;
        end
    end

    always_comb begin
        order.order_instrument = item.instrument;
        order.order_number     = order_number;
        if (do_buy) begin
            order.order_kind  = ecos_pkg::KIND_BUY;
            order.order_side  = ecos_pkg::SIDE_BID;
            order.order_price = 29'(bid) + 29'(cfg.tick_step);
            order.order_qty   = 11'(cfg.lot_size);
        end else if (do_sell) begin
            order.order_kind  = ecos_pkg::KIND_SELL;
            order.order_side  = ecos_pkg::SIDE_ASK;
            order.order_price = 29'(ask) - 29'(cfg.tick_step);
            order.order_qty   = 11'(cfg.lot_size);
        end else if (pos > 12'sd0) begin
            order.order_kind  = ecos_pkg::KIND_CLOSE;
            order.order_side  = ecos_pkg::SIDE_ASK;
            order.order_price = 29'(ask);
            order.order_qty   = pos[10:0];
        end else begin
            order.order_kind  = ecos_pkg::KIND_CLOSE;
            order.order_side  = ecos_pkg::SIDE_BID;
            order.order_price = 29'(bid);
            order.order_qty   = 11'(-pos);
        end
    end

endmodule

@@ verif/ecos_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecos_checker: order prediction and comparison for the EMA crossover block
// Watches the quote, order and register-write ports, keeps its own copy of
// the per-instrument averages, volatility and position, forecasts the order
// that each accepted request should produce and compares every accepted
// order with the oldest forecast, field by field.
// ----------------------------------------------------------------------------
module ecos_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  ecos_pkg::in_item_t               s_payload,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  ecos_pkg::order_t                 m_payload,
    input  logic                             cfg_wr_en,
    input  logic [ecos_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [ecos_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output int                               pending_orders,
    output int                               error_count
);
    import ecos_pkg::*;

    localparam int INST_COUNT = 256;

    logic [16:0] w_fast;
    logic [16:0] w_slow;
    logic [55:0] vol_ceiling;
    logic [31:0] band_gap;
    logic [9:0]  pos_cap;
    logic [9:0]  lot_qty;
    logic [9:0]  tick_cents;

    longint      fast_track [INST_COUNT];
    longint      slow_track [INST_COUNT];
    logic [63:0] vol_acc    [INST_COUNT];
    longint      mid_track  [INST_COUNT];
    int          position   [INST_COUNT];
    bit          primed     [INST_COUNT];
    logic [63:0] next_order_id;

    order_t awaited_orders[$];
    int     mismatches;

    function automatic longint blend(input longint avg, input longint target,
                                     input logic [16:0] w);
        longint wc;
        wc = (w > WEIGHT_ONE) ? 65536 : w;
        return avg + ((wc * (target - avg)) >>> 16);
    endfunction

    function automatic bit forecast_order(input in_item_t q, output order_t ord);
        int          idx;
        longint      bid, ask, mid, scaled, delta, diff, band, price, qty, tick;
        logic [63:0] sq;
        int          pos, cap, lot;
        logic [1:0]  kind;
        logic        side;
        ord = '0;
        idx = q.instrument;
        bid = q.bid_price;
        ask = q.ask_price;
        if (q.levels == 0 || bid == 0 || ask == 0 || ask <= bid) begin
            return 0;
        end
        mid = (bid + ask) >> 1;
        scaled = mid << 16;
        if (!primed[idx]) begin
            fast_track[idx] = scaled;
            slow_track[idx] = scaled;
            mid_track[idx] = mid;
            primed[idx] = 1'b1;
            return 0;
        end
        fast_track[idx] = blend(fast_track[idx], scaled, w_fast);
        slow_track[idx] = blend(slow_track[idx], scaled, w_slow);
        delta = mid - mid_track[idx];
        sq = delta * delta;
        vol_acc[idx] = (vol_acc[idx] * 64'd127 + sq) >> 7;
        mid_track[idx] = mid;
        tick = tick_cents;
        if (vol_acc[idx] > {8'd0, vol_ceiling} || (ask - bid) < tick) begin
            return 0;
        end
        diff = fast_track[idx] - slow_track[idx];
        band = band_gap;
        pos = position[idx];
        cap = pos_cap;
        lot = lot_qty;
        if (diff > band && pos < cap) begin
            kind = KIND_BUY;
            side = SIDE_BID;
            price = bid + tick;
            qty = lot;
            position[idx] = pos + lot;
        end else if (diff < -band && pos > -cap) begin
            kind = KIND_SELL;
            side = SIDE_ASK;
            price = ask - tick;
            qty = lot;
            position[idx] = pos - lot;
        end else if ((pos > 0 && diff < 0) || (pos < 0 && diff > 0)) begin
            kind = KIND_CLOSE;
            side = (pos > 0) ? SIDE_ASK : SIDE_BID;
            price = (pos > 0) ? ask : bid;
            qty = (pos > 0) ? pos : -pos;
            position[idx] = 0;
        end else begin
            return 0;
        end
        ord.order_instrument = q.instrument;
        ord.order_number = next_order_id;
        ord.order_kind = kind;
        ord.order_side = side;
        ord.order_price = 29'(price);
        ord.order_qty = 11'(qty);
        next_order_id = next_order_id + 64'd1;
        return 1;
    endfunction

    function automatic string show(input order_t o);
        return $sformatf("inst %0d number %0d kind %0d side %0d price %0d qty %0d",
                         o.order_instrument, o.order_number, o.order_kind,
                         o.order_side, o.order_price, o.order_qty);
    endfunction

    always @(posedge aclk) begin
        order_t want;
        order_t made;
        if (!aresetn) begin
            w_fast = 17'd6553;
            w_slow = 17'd1310;
            vol_ceiling = 56'd429496729600;
            band_gap = 32'd131072;
            pos_cap = 10'd1000;
            lot_qty = 10'd100;
            tick_cents = 10'd1;
            for (int i = 0; i < INST_COUNT; i++) begin
                fast_track[i] = 0;
                slow_track[i] = 0;
                vol_acc[i] = '0;
                mid_track[i] = 0;
                position[i] = 0;
                primed[i] = 1'b0;
            end
            next_order_id = 64'd1;
            awaited_orders.delete();
            mismatches = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_orders.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected order: %s", show(m_payload));
                    end
                end else begin
                    want = awaited_orders.pop_front();
                    if (m_payload.order_instrument !== want.order_instrument ||
                        m_payload.order_number !== want.order_number ||
                        m_payload.order_kind !== want.order_kind ||
                        m_payload.order_side !== want.order_side ||
                        m_payload.order_price !== want.order_price ||
                        m_payload.order_qty !== want.order_qty) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("order mismatch: expected %s", show(want));
                            $display("                actual   %s", show(m_payload));
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (forecast_order(s_payload, made)) begin
                    awaited_orders.push_back(made);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_FAST_WEIGHT: w_fast = cfg_wr_data[16:0];
                    REG_SLOW_WEIGHT: w_slow = cfg_wr_data[16:0];
                    REG_VOLATILITY_LIMIT: vol_ceiling = cfg_wr_data[55:0];
                    REG_CROSS_BAND: band_gap = cfg_wr_data[31:0];
                    REG_POSITION_LIMIT: pos_cap = cfg_wr_data[9:0];
                    REG_LOT_SIZE: lot_qty = cfg_wr_data[9:0];
                    REG_TICK_STEP: tick_cents = cfg_wr_data[9:0];
                    default: ;
                endcase
            end
        end
        pending_orders <= awaited_orders.size();
        error_count <= mismatches;
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the EMA crossover order block
// Drives quote requests with random idle gaps and order acceptance with random
// stalls, plus register writes: a short directed run over invalid books, seeding,
// buys, sells, closes and suppressed orders, then random trending markets under
// several register settings. The checker predicts and compares; this module gives
// the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import ecos_pkg::*;

    localparam int     LIMIT_CYCLES = 200000;
    localparam longint PRICE_TOP = 268435455;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_payload;
    logic                   m_valid;
    logic                   m_ready;
    order_t                 m_payload;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_wr_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;
    int                     pending_orders;
    int                     error_count;
    int                     cycle_count = 0;
    bit                     send_rush = 0;
    bit                     take_rush = 0;
    cfg_t                   live_cfg = CFG_RESET;

    ema_crossover_order_signal u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_payload    (s_payload),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_payload    (m_payload),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    ecos_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload      (m_payload),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_index   (cfg_wr_index),
        .cfg_wr_data    (cfg_wr_data),
        .pending_orders (pending_orders),
        .error_count    (error_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int draw_wait(inout bit rush);
        if ($urandom_range(0, 39) == 0) begin
            rush = !rush;
        end
        return rush ? 0 : int'($urandom_range(0, 18));
    endfunction

    function automatic in_item_t book(input logic [7:0] inst, input logic [3:0] lv,
                                      input logic [27:0] bid, input logic [27:0] ask);
        in_item_t q;
        q.instrument = inst;
        q.levels = lv;
        q.bid_price = bid;
        q.ask_price = ask;
        return q;
    endfunction

    task automatic send_quote(input in_item_t q);
        int gap;
        s_payload <= q;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        gap = draw_wait(send_rush);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    task automatic load_config(input cfg_t c);
        write_reg(REG_FAST_WEIGHT, CFG_DATA_W'(c.fast_weight));
        write_reg(REG_SLOW_WEIGHT, CFG_DATA_W'(c.slow_weight));
        write_reg(REG_VOLATILITY_LIMIT, CFG_DATA_W'(c.volatility_limit));
        write_reg(REG_CROSS_BAND, CFG_DATA_W'(c.cross_band));
        write_reg(REG_POSITION_LIMIT, CFG_DATA_W'(c.position_limit));
        write_reg(REG_LOT_SIZE, CFG_DATA_W'(c.lot_size));
        write_reg(REG_TICK_STEP, CFG_DATA_W'(c.tick_step));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        live_cfg = c;
    endtask

    task automatic quiesce();
        s_valid <= 1'b0;
        repeat (3) @(posedge aclk);
        while (pending_orders != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Most requests follow a few trending instruments so that the averages
    // cross and orders come out; the rest are random or malformed books.
    task automatic run_market(input int count);
        logic [7:0] names [6];
        longint     mid [6];
        longint     drift [6];
        in_item_t   q;
        int         k, r, spread, tick;
        longint     lo;
        for (k = 0; k < 6; k++) begin
            names[k] = 8'($urandom_range(0, 255));
            mid[k] = $urandom_range(5000, 268430000);
            drift[k] = int'($urandom_range(0, 800)) - 400;
        end
        tick = live_cfg.tick_step;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, 5);
            if (r < 8) begin
                q.instrument = 8'($urandom);
                q.levels = 4'($urandom);
                q.bid_price = 28'($urandom);
                q.ask_price = 28'($urandom);
            end else if (r < 14) begin
                q = book(names[k], 4'($urandom_range(1, 15)), 28'(mid[k]), 28'(mid[k] + 10));
                case ($urandom_range(0, 3))
                    0: q.levels = 4'd0;
                    1: q.bid_price = 28'd0;
                    2: q.ask_price = 28'd0;
                    default: q.ask_price = 28'(mid[k] - $urandom_range(0, 50));
                endcase
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    drift[k] = int'($urandom_range(0, 800)) - 400;
                end
                mid[k] = mid[k] + drift[k] + int'($urandom_range(0, 40)) - 20;
                if (mid[k] < 3000) begin
                    mid[k] = 3000;
                end
                if (mid[k] > PRICE_TOP - 3000) begin
                    mid[k] = PRICE_TOP - 3000;
                end
                spread = $urandom_range(1, 2 * tick + 4);
                lo = mid[k] - spread / 2;
                q = book(names[k], 4'($urandom_range(1, 15)), 28'(lo), 28'(lo + spread));
            end
            send_quote(q);
        end
    endtask

    initial begin
        int m_stall;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            m_stall = draw_wait(take_rush);
            if (m_stall > 0) begin
                m_ready <= 1'b0;
                repeat (m_stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin
        cfg_t c;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_payload <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_index <= '0;
        cfg_wr_data <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Malformed books, seeding, a rising then a falling run and the
        // price extremes, all under the reset settings.
        send_quote(book(8'd9, 4'd0, 28'd5000, 28'd5010));
        send_quote(book(8'd9, 4'd3, 28'd0, 28'd5010));
        send_quote(book(8'd9, 4'd3, 28'd5000, 28'd0));
        send_quote(book(8'd9, 4'd3, 28'd5000, 28'd5000));
        send_quote(book(8'd9, 4'd3, 28'd5010, 28'd5000));
        send_quote(book(8'd1, 4'd1, 28'd10000, 28'd10002));
        for (int j = 1; j <= 4; j++) begin
            send_quote(book(8'd1, 4'd15, 28'(10000 + 200 * j), 28'(10002 + 200 * j)));
        end
        for (int j = 1; j <= 6; j++) begin
            send_quote(book(8'd1, 4'd4, 28'(10800 - 300 * j), 28'(10802 - 300 * j)));
        end
        send_quote(book(8'd255, 4'd15, 28'hFFFFFFE, 28'hFFFFFFF));
        send_quote(book(8'd255, 4'd8, 28'd1, 28'hFFFFFFF));
        send_quote(book(8'd0, 4'd1, 28'd1, 28'd2));
        send_quote(book(8'd0, 4'd10, 28'd1, 28'd3));
        quiesce();

        // With an unreachable band only closes remain; a wide tick makes
        // narrow spreads suppress the order.
        write_reg(REG_CROSS_BAND, CFG_DATA_W'(32'hFFFFFFFF));
        write_reg(REG_TICK_STEP, CFG_DATA_W'(10'd1000));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        live_cfg.cross_band = 32'hFFFFFFFF;
        live_cfg.tick_step = 10'd1000;
        send_quote(book(8'd1, 4'd2, 28'd9000, 28'd9400));
        send_quote(book(8'd1, 4'd2, 28'd8000, 28'd9500));
        send_quote(book(8'd1, 4'd2, 28'd12000, 28'd13500));
        send_quote(book(8'd1, 4'd2, 28'd7000, 28'd8500));
        quiesce();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: c = CFG_RESET;
                1: c = '{fast_weight: 17'h1FFFF, slow_weight: 17'd0,
                         volatility_limit: '1, cross_band: 32'd0,
                         position_limit: 10'h3FF, lot_size: 10'h3FF, tick_step: 10'h3FF};
                2: c = '{fast_weight: 17'd0, slow_weight: WEIGHT_ONE,
                         volatility_limit: '0, cross_band: 32'd0,
                         position_limit: 10'd0, lot_size: 10'd0, tick_step: 10'd0};
                default: begin
                    c.fast_weight = 17'($urandom_range(0, 131071));
                    c.slow_weight = 17'($urandom_range(0, 131071));
                    c.volatility_limit = (phase == 3) ? 56'({$urandom, $urandom})
                                                      : 56'($urandom_range(0, 400000));
                    c.cross_band = (phase == 3) ? 32'($urandom)
                                                : 32'($urandom_range(0, 262144));
                    c.position_limit = 10'($urandom_range(0, 1023));
                    c.lot_size = 10'($urandom_range(0, 1023));
                    c.tick_step = 10'($urandom_range(0, 1023));
                end
            endcase
            load_config(c);
            run_market((phase == 2) ? 60 : 110);
            quiesce();
        end

        if (error_count == 0 && pending_orders == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
